/* hdl/cpcr_pkg.sv */
package cpcr_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned PosW        = 32;
  localparam int unsigned RadW        = 30;
  localparam int unsigned MagW        = PosW + 1;
  localparam int unsigned SqW         = 2 * MagW;
  localparam int unsigned RsumW       = RadW + 1;
  localparam int unsigned RootW       = 34;
  localparam int unsigned PenW        = 34;
  localparam int unsigned KShift      = 20;
  localparam logic [KShift-1:0] KNum  = 20'd523239;

  typedef struct packed {
    logic signed [PosW-1:0] a_pos_x;
    logic signed [PosW-1:0] a_pos_y;
    logic signed [PosW-1:0] b_pos_x;
    logic signed [PosW-1:0] b_pos_y;
    logic signed [PosW-1:0] b_next_x;
    logic signed [PosW-1:0] b_next_y;
    logic [RadW-1:0]        a_radius;
    logic [RadW-1:0]        b_radius;
    logic                   a_trigger;
    logic                   b_trigger;
  } in_word_t;

  typedef struct packed {
    logic                   contact;
    logic                   resolved;
    logic signed [PosW-1:0] b_next_x_out;
    logic signed [PosW-1:0] b_next_y_out;
  } out_word_t;

  typedef struct packed {
    logic                   contact;
    logic                   resolved;
    logic                   dx_neg;
    logic                   dy_neg;
    logic [MagW-1:0]        dx_mag;
    logic [MagW-1:0]        dy_mag;
    logic [RsumW-1:0]       rsum;
    logic signed [PosW-1:0] nx;
    logic signed [PosW-1:0] ny;
  } sq_side_t;

  typedef struct packed {
    logic                   contact;
    logic                   resolved;
    logic                   len_zero;
    logic                   dx_neg;
    logic                   dy_neg;
    logic                   pen_neg;
    logic [PenW-1:0]        pen_mag;
    logic signed [PosW-1:0] nx;
    logic signed [PosW-1:0] ny;
  } dv_side_t;

  // Returns the sign and the magnitude of a - b.
  function automatic logic [MagW:0] diff_abs(input logic [PosW-1:0] a,
                                             input logic [PosW-1:0] b);
    logic [MagW-1:0] d;
    logic [MagW-1:0] m;
    d = {a[PosW-1], a} - {b[PosW-1], b};
    m = d[MagW-1] ? (~d + MagW'(1)) : d;
    return {d[MagW-1], m};
  endfunction

endpackage

/* hdl/cpcr_isqrt.sv */
module cpcr_isqrt import cpcr_pkg::*; #(
  parameter int unsigned RootBits = RootW,
  parameter int unsigned SideW    = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [2*RootBits-1:0] rad_i,
  input  logic [SideW-1:0]      side_i,
  output logic                  valid_o,
  output logic [RootBits-1:0]   root_o,
  output logic [SideW-1:0]      side_o
);

  localparam int unsigned StepsPerStage = 2;
  localparam int unsigned Stages = (RootBits + StepsPerStage - 1) / StepsPerStage;
  localparam int unsigned RemW = RootBits + 2;

  logic [Stages-1:0]     vld_q;
  logic [2*RootBits-1:0] rad_q  [Stages];
  logic [RemW-1:0]       rem_q  [Stages];
  logic [RootBits-1:0]   root_q [Stages];
  logic [SideW-1:0]      side_q [Stages];

  function automatic logic [RootBits+RemW-1:0] sq_step(input logic [RemW-1:0] rem,
                                                       input logic [RootBits-1:0] root,
                                                       input logic [1:0] pair);
    logic [RemW-1:0] r;
    logic [RemW-1:0] trial;
    logic [RootBits+RemW-1:0] res;
    r = {rem[RemW-3:0], pair};
    trial = {root, 2'b01};
    if (r >= trial) begin
      res = {root[RootBits-2:0], 1'b1, r - trial};
    end else begin
      res = {root[RootBits-2:0], 1'b0, r};
    end
    return res;
  endfunction

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic                  v_in;
    logic [2*RootBits-1:0] rad_in;
    logic [RemW-1:0]       rem_in;
    logic [RootBits-1:0]   root_in;
    logic [SideW-1:0]      side_in;
    logic [2*RootBits-1:0] rad_d;
    logic [RemW-1:0]       rem_d;
    logic [RootBits-1:0]   root_d;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = vld_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin
      rad_d  = rad_in;
      rem_d  = rem_in;
      root_d = root_in;
      for (int k = 0; k < StepsPerStage; k++) begin
        if (s * StepsPerStage + k < RootBits) begin
          {root_d, rem_d} = sq_step(rem_d, root_d, rad_d[2*RootBits-1 -: 2]);
          rad_d = {rad_d[2*RootBits-3:0], 2'b00};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[s]  <= rad_d;
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[Stages-1];
  assign root_o  = root_q[Stages-1];
  assign side_o  = side_q[Stages-1];

endmodule

/* hdl/cpcr_div.sv */
module cpcr_div import cpcr_pkg::*; #(
  parameter int unsigned QuotW = FracBitsDef + 1,
  parameter int unsigned NumW  = MagW,
  parameter int unsigned DenW  = RootW,
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num0_i,
  input  logic [NumW-1:0]  num1_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [QuotW-1:0] quot0_o,
  output logic [QuotW-1:0] quot1_o,
  output logic [SideW-1:0] side_o
);

  localparam int unsigned StepsPerStage = 2;
  localparam int unsigned Stages = (QuotW + StepsPerStage - 1) / StepsPerStage;
  localparam int unsigned RemW = DenW + 1;

  logic [Stages-1:0] vld_q;
  logic [RemW-1:0]   rem0_q [Stages];
  logic [RemW-1:0]   rem1_q [Stages];
  logic [QuotW-1:0]  quo0_q [Stages];
  logic [QuotW-1:0]  quo1_q [Stages];
  logic [DenW-1:0]   den_q  [Stages];
  logic [SideW-1:0]  side_q [Stages];

  // The first step compares the numerator as it is, each later one shifts it left first.
  function automatic logic [RemW:0] dv_step(input logic [RemW-1:0] rem,
                                            input logic [DenW-1:0] den,
                                            input logic first);
    logic [RemW-1:0] r;
    logic [RemW:0] res;
    r = first ? rem : {rem[RemW-2:0], 1'b0};
    if (r >= RemW'(den)) begin
      res = {1'b1, r - RemW'(den)};
    end else begin
      res = {1'b0, r};
    end
    return res;
  endfunction

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic             v_in;
    logic [RemW-1:0]  rem0_in;
    logic [RemW-1:0]  rem1_in;
    logic [QuotW-1:0] quo0_in;
    logic [QuotW-1:0] quo1_in;
    logic [DenW-1:0]  den_in;
    logic [SideW-1:0] side_in;
    logic [RemW-1:0]  rem0_d;
    logic [RemW-1:0]  rem1_d;
    logic [QuotW-1:0] quo0_d;
    logic [QuotW-1:0] quo1_d;
    logic             bit0;
    logic             bit1;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem0_in = RemW'(num0_i);
      assign rem1_in = RemW'(num1_i);
      assign quo0_in = '0;
      assign quo1_in = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = vld_q[s-1];
      assign rem0_in = rem0_q[s-1];
      assign rem1_in = rem1_q[s-1];
      assign quo0_in = quo0_q[s-1];
      assign quo1_in = quo1_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin
      rem0_d = rem0_in;
      rem1_d = rem1_in;
      quo0_d = quo0_in;
      quo1_d = quo1_in;
      bit0   = 1'b0;
      bit1   = 1'b0;
      for (int k = 0; k < StepsPerStage; k++) begin
        if (s * StepsPerStage + k < QuotW) begin
          {bit0, rem0_d} = dv_step(rem0_d, den_in, (s * StepsPerStage + k) == 0);
          {bit1, rem1_d} = dv_step(rem1_d, den_in, (s * StepsPerStage + k) == 0);
          quo0_d = {quo0_d[QuotW-2:0], bit0};
          quo1_d = {quo1_d[QuotW-2:0], bit1};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem0_q[s] <= rem0_d;
        rem1_q[s] <= rem1_d;
        quo0_q[s] <= quo0_d;
        quo1_q[s] <= quo1_d;
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[Stages-1];
  assign quot0_o = quo0_q[Stages-1];
  assign quot1_o = quo1_q[Stages-1];
  assign side_o  = side_q[Stages-1];

endmodule

/* hdl/circle_pair_collide_resolve_core.sv */
// Channel  Direction  Word        Handshake
// in       input      in_word_i   in_valid_i / in_stall_o
// out      output     out_word_o  out_valid_o / out_stall_i
//
// One word enters per cycle unless a held output word stalls the pipeline.
// The pipeline holds the square root, two root bits per stage, and the two normal
// dividers, two quotient bits per stage.
// Reset clears only the stage valid bits.
// A stalled output word freezes the whole pipeline; no word is lost or repeated.
module circle_pair_collide_resolve_core import cpcr_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int unsigned QuotW  = FRAC_BITS + 1;
  localparam int unsigned ProdTW = QuotW + PenW;
  localparam int unsigned ProdPW = PenW + KShift;
  localparam int unsigned SumW   = PenW + 2;

  logic en;

  logic                   s1_vld_q;
  logic [MagW-1:0]        s1_cdx_q;
  logic [MagW-1:0]        s1_cdy_q;
  logic [MagW-1:0]        s1_dx_q;
  logic [MagW-1:0]        s1_dy_q;
  logic                   s1_dxn_q;
  logic                   s1_dyn_q;
  logic [RsumW-1:0]       s1_rsum_q;
  logic                   s1_trig_q;
  logic signed [PosW-1:0] s1_nx_q;
  logic signed [PosW-1:0] s1_ny_q;
  logic [MagW:0]          cd_x;
  logic [MagW:0]          cd_y;
  logic [MagW:0]          d_x;
  logic [MagW:0]          d_y;

  logic                   s2_vld_q;
  logic [SqW-1:0]         s2_cdx2_q;
  logic [SqW-1:0]         s2_cdy2_q;
  logic [SqW-1:0]         s2_dx2_q;
  logic [SqW-1:0]         s2_dy2_q;
  logic [2*RsumW-1:0]     s2_rs2_q;
  logic [MagW-1:0]        s2_dx_q;
  logic [MagW-1:0]        s2_dy_q;
  logic                   s2_dxn_q;
  logic                   s2_dyn_q;
  logic [RsumW-1:0]       s2_rsum_q;
  logic                   s2_trig_q;
  logic signed [PosW-1:0] s2_nx_q;
  logic signed [PosW-1:0] s2_ny_q;

  logic                   s3_vld_q;
  logic [2*RootW-1:0]     s3_rad_q;
  sq_side_t               s3_side_q;
  sq_side_t               s3_side_d;
  logic [SqW-1:0]         dc_sum;
  logic [SqW-1:0]         ds_sum;

  logic                   sq_vld;
  logic [RootW-1:0]       sq_root;
  sq_side_t               sq_side;
  logic [PenW:0]          pen_w;
  dv_side_t               dv_side_in;

  logic                   dv_vld;
  logic [QuotW-1:0]       dv_qx;
  logic [QuotW-1:0]       dv_qy;
  dv_side_t               dv_side;
  logic [ProdTW-1:0]      tx_prod;
  logic [ProdTW-1:0]      ty_prod;

  logic                   m1_vld_q;
  logic [PenW-1:0]        m1_tx_q;
  logic [PenW-1:0]        m1_ty_q;
  dv_side_t               m1_side_q;
  logic [ProdPW-1:0]      px_prod;
  logic [ProdPW-1:0]      py_prod;

  logic                   m2_vld_q;
  logic [PenW-1:0]        m2_px_q;
  logic [PenW-1:0]        m2_py_q;
  dv_side_t               m2_side_q;

  logic                   out_valid_q;
  out_word_t              out_q;
  out_word_t              out_d;

  function automatic logic [PosW-1:0] push_sat(input logic [PosW-1:0] pos,
                                               input logic [PenW-1:0] mag,
                                               input logic neg);
    logic [SumW-1:0] ext;
    logic [SumW-1:0] sum;
    logic [PosW-1:0] res;
    ext = neg ? (~SumW'(mag) + SumW'(1)) : SumW'(mag);
    sum = {{(SumW-PosW){pos[PosW-1]}}, pos} + ext;
    if (!sum[SumW-1] && (sum[SumW-2:PosW-1] != '0)) begin
      res = {1'b0, {(PosW-1){1'b1}}};
    end else if (sum[SumW-1] && (sum[SumW-2:PosW-1] != '1)) begin
      res = {1'b1, {(PosW-1){1'b0}}};
    end else begin
      res = sum[PosW-1:0];
    end
    return res;
  endfunction

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  assign cd_x = diff_abs(in_word_i.a_pos_x, in_word_i.b_pos_x);
  assign cd_y = diff_abs(in_word_i.a_pos_y, in_word_i.b_pos_y);
  assign d_x  = diff_abs(in_word_i.b_next_x, in_word_i.a_pos_x);
  assign d_y  = diff_abs(in_word_i.b_next_y, in_word_i.a_pos_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      s3_vld_q    <= 1'b0;
      m1_vld_q    <= 1'b0;
      m2_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_vld_q    <= in_valid_i;
      s2_vld_q    <= s1_vld_q;
      s3_vld_q    <= s2_vld_q;
      m1_vld_q    <= dv_vld;
      m2_vld_q    <= m1_vld_q;
      out_valid_q <= m2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_cdx_q  <= cd_x[MagW-1:0];
      s1_cdy_q  <= cd_y[MagW-1:0];
      s1_dx_q   <= d_x[MagW-1:0];
      s1_dy_q   <= d_y[MagW-1:0];
      s1_dxn_q  <= d_x[MagW];
      s1_dyn_q  <= d_y[MagW];
      s1_rsum_q <= RsumW'(in_word_i.a_radius) + RsumW'(in_word_i.b_radius);
      s1_trig_q <= in_word_i.a_trigger | in_word_i.b_trigger;
      s1_nx_q   <= in_word_i.b_next_x;
      s1_ny_q   <= in_word_i.b_next_y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_cdx2_q <= SqW'(s1_cdx_q) * SqW'(s1_cdx_q);
      s2_cdy2_q <= SqW'(s1_cdy_q) * SqW'(s1_cdy_q);
      s2_dx2_q  <= SqW'(s1_dx_q) * SqW'(s1_dx_q);
      s2_dy2_q  <= SqW'(s1_dy_q) * SqW'(s1_dy_q);
      s2_rs2_q  <= (2*RsumW)'(s1_rsum_q) * (2*RsumW)'(s1_rsum_q);
      s2_dx_q   <= s1_dx_q;
      s2_dy_q   <= s1_dy_q;
      s2_dxn_q  <= s1_dxn_q;
      s2_dyn_q  <= s1_dyn_q;
      s2_rsum_q <= s1_rsum_q;
      s2_trig_q <= s1_trig_q;
      s2_nx_q   <= s1_nx_q;
      s2_ny_q   <= s1_ny_q;
    end
  end

  assign dc_sum = s2_cdx2_q + s2_cdy2_q;
  assign ds_sum = s2_dx2_q + s2_dy2_q;

  always_comb begin
    s3_side_d          = '0;
    s3_side_d.contact  = SqW'(s2_rs2_q) > dc_sum;
    s3_side_d.resolved = s3_side_d.contact && !s2_trig_q;
    s3_side_d.dx_neg   = s2_dxn_q;
    s3_side_d.dy_neg   = s2_dyn_q;
    s3_side_d.dx_mag   = s2_dx_q;
    s3_side_d.dy_mag   = s2_dy_q;
    s3_side_d.rsum     = s2_rsum_q;
    s3_side_d.nx       = s2_nx_q;
    s3_side_d.ny       = s2_ny_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_rad_q  <= (2*RootW)'(ds_sum);
      s3_side_q <= s3_side_d;
    end
  end

  cpcr_isqrt #(
    .RootBits (RootW),
    .SideW    ($bits(sq_side_t))
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_vld_q),
    .rad_i   (s3_rad_q),
    .side_i  (s3_side_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  assign pen_w = (PenW+1)'(sq_side.rsum) - (PenW+1)'(sq_root);

  always_comb begin
    dv_side_in          = '0;
    dv_side_in.contact  = sq_side.contact;
    dv_side_in.resolved = sq_side.resolved;
    dv_side_in.len_zero = sq_root == '0;
    dv_side_in.dx_neg   = sq_side.dx_neg;
    dv_side_in.dy_neg   = sq_side.dy_neg;
    dv_side_in.pen_neg  = pen_w[PenW];
    dv_side_in.pen_mag  = pen_w[PenW] ? PenW'(~pen_w + (PenW+1)'(1)) : pen_w[PenW-1:0];
    dv_side_in.nx       = sq_side.nx;
    dv_side_in.ny       = sq_side.ny;
  end

  cpcr_div #(
    .QuotW (QuotW),
    .NumW  (MagW),
    .DenW  (RootW),
    .SideW ($bits(dv_side_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld),
    .num0_i  (sq_side.dx_mag),
    .num1_i  (sq_side.dy_mag),
    .den_i   (sq_root),
    .side_i  (dv_side_in),
    .valid_o (dv_vld),
    .quot0_o (dv_qx),
    .quot1_o (dv_qy),
    .side_o  (dv_side)
  );

  assign tx_prod = ProdTW'(dv_qx) * ProdTW'(dv_side.pen_mag);
  assign ty_prod = ProdTW'(dv_qy) * ProdTW'(dv_side.pen_mag);

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_tx_q   <= tx_prod[FRAC_BITS +: PenW];
      m1_ty_q   <= ty_prod[FRAC_BITS +: PenW];
      m1_side_q <= dv_side;
    end
  end

  assign px_prod = ProdPW'(m1_tx_q) * ProdPW'(KNum);
  assign py_prod = ProdPW'(m1_ty_q) * ProdPW'(KNum);

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_px_q   <= px_prod[KShift +: PenW];
      m2_py_q   <= py_prod[KShift +: PenW];
      m2_side_q <= m1_side_q;
    end
  end

  always_comb begin
    out_d          = '0;
    out_d.contact  = m2_side_q.contact;
    out_d.resolved = m2_side_q.resolved;
    if (m2_side_q.resolved && !m2_side_q.len_zero) begin
      out_d.b_next_x_out = push_sat(m2_side_q.nx, m2_px_q,
                                    m2_side_q.dx_neg ^ m2_side_q.pen_neg);
      out_d.b_next_y_out = push_sat(m2_side_q.ny, m2_py_q,
                                    m2_side_q.dy_neg ^ m2_side_q.pen_neg);
    end else begin
      out_d.b_next_x_out = m2_side_q.nx;
      out_d.b_next_y_out = m2_side_q.ny;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_resolved_needs_contact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.contact || !out_word_o.resolved))
    else $error("Resolved word without contact.");

  a_normal_x_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_vld && !dv_side.len_zero) |-> (dv_qx <= (QuotW'(1) << FRAC_BITS)))
    else $error("Normal x component exceeds one.");

  a_normal_y_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_vld && !dv_side.len_zero) |-> (dv_qy <= (QuotW'(1) << FRAC_BITS)))
    else $error("Normal y component exceeds one.");

endmodule
